@@ rtl/bpq_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpq_pkg
// Shared types and constants of the bounded priority queue: storage sizes,
// entry layout, opcodes, status codes and sequencer states.
// ----------------------------------------------------------------------------
package bpq_pkg;

   localparam int DEPTH     = 16;
   localparam int PRIO_W    = 8;
   localparam int PAYLOAD_W = 32;
   localparam int ADDR_W    = $clog2(DEPTH);
   localparam int CNT_W     = 5;
   localparam int ENTRY_W   = PRIO_W + PAYLOAD_W;

   localparam logic [CNT_W-1:0] LIMIT_RESET = CNT_W'(16);
   localparam logic [CNT_W-1:0] DEPTH_CNT   = CNT_W'(DEPTH);

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_DELETE = 1'b1;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_OVERFLOW  = 2'd1,
      STATUS_UNDERFLOW = 2'd2
   } status_type;

   typedef struct packed {
      logic [PRIO_W-1:0]    prio;
      logic [PAYLOAD_W-1:0] payload;
   } entry_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_INS_CMP,
      S_INS_PLACE,
      S_DEL_HEAD,
      S_DEL_SHIFT,
      S_RESP
   } state_type;

endpackage

@@ rtl/bpq_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpq_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module bpq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/bounded_priority_queue_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_priority_queue_top
// Sorted priority queue, highest priority at the head, arrival order kept
// among equals. Entries live in one RAM; a sequencer shifts them one entry
// per cycle through a single compare unit.
// ----------------------------------------------------------------------------
//  channel  direction  handshake             payload
//  req      in         req_valid/req_stall   opcode, priority_req, payload
//  rsp      out        rsp_valid/rsp_stall   status, removed_priority,
//                                            removed_payload, occupancy
//  csr      in         csr_wr_en             capacity_limit
//
//  insert moving k held entries: one RAM read and one compare per entry moved.
//  delete of n held entries: one entry moved per cycle over
//  the single RAM read port.
//  overflow and underflow answer without a RAM access.
//  reset clears count and sets the limit to 16; no clearing pass on the RAM.
//  a new item is taken while a result waits on rsp_stall; the next result
//  then holds until the output register frees.
// ----------------------------------------------------------------------------
module bounded_priority_queue_top (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_opcode,
   input  logic [bpq_pkg::PRIO_W-1:0]     req_priority_req,
   input  logic [bpq_pkg::PAYLOAD_W-1:0]  req_payload,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [1:0]                     rsp_status,
   output logic [bpq_pkg::PRIO_W-1:0]     rsp_removed_priority,
   output logic [bpq_pkg::PAYLOAD_W-1:0]  rsp_removed_payload,
   output logic [bpq_pkg::CNT_W-1:0]      rsp_occupancy,
   input  logic                           csr_wr_en,
   input  logic [bpq_pkg::CNT_W-1:0]      csr_wr_data
);

   localparam int AW = bpq_pkg::ADDR_W;
   localparam int CW = bpq_pkg::CNT_W;

   bpq_pkg::state_type             state_ff, state_in;
   logic [CW-1:0]                  count_ff, count_in;
   logic [CW-1:0]                  limit_ff;
   logic [AW-1:0]                  idx_ff, idx_in;
   bpq_pkg::entry_type             new_ff, new_in;
   bpq_pkg::status_type            res_status_ff, res_status_in;
   bpq_pkg::entry_type             res_entry_ff, res_entry_in;

   logic                           rsp_valid_ff, rsp_valid_in;
   bpq_pkg::status_type            rsp_status_ff, rsp_status_in;
   bpq_pkg::entry_type             rsp_entry_ff, rsp_entry_in;
   logic [CW-1:0]                  rsp_occ_ff, rsp_occ_in;

   logic                           wr_en, rd_en;
   logic [AW-1:0]                  wr_addr, rd_addr;
   bpq_pkg::entry_type             wr_data, rd_data;

   logic [CW-1:0]                  eff_limit;
   logic [CW-1:0]                  cnt_m1;
   logic [CW-1:0]                  idx_p1;
   logic                           req_take;
   logic                           out_free;

   bpq_ram #(
      .WIDTH (bpq_pkg::ENTRY_W),
      .DEPTH (bpq_pkg::DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign eff_limit = (limit_ff > bpq_pkg::DEPTH_CNT) ? bpq_pkg::DEPTH_CNT : limit_ff;
   assign cnt_m1    = count_ff - CW'(1);
   assign idx_p1    = CW'(idx_ff) + CW'(1);
   assign req_stall = (state_ff != bpq_pkg::S_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bpq_pkg::S_IDLE;
         count_ff     <= '0;
         limit_ff     <= bpq_pkg::LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            limit_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      new_ff        <= new_in;
      res_status_ff <= res_status_in;
      res_entry_ff  <= res_entry_in;
      rsp_status_ff <= rsp_status_in;
      rsp_entry_ff  <= rsp_entry_in;
      rsp_occ_ff    <= rsp_occ_in;
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      new_in        = new_ff;
      res_status_in = res_status_ff;
      res_entry_in  = res_entry_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_entry_in  = rsp_entry_ff;
      rsp_occ_in    = rsp_occ_ff;
      wr_en         = 1'b0;
      wr_addr       = idx_ff;
      wr_data       = rd_data;
      rd_en         = 1'b0;
      rd_addr       = idx_ff;

      unique case (state_ff)
         bpq_pkg::S_IDLE: begin
            if (req_take) begin
               new_in.prio    = req_priority_req;
               new_in.payload = req_payload;
               res_status_in  = bpq_pkg::STATUS_OK;
               res_entry_in   = '0;
               if (req_opcode == bpq_pkg::OP_INSERT) begin
                  if (count_ff >= eff_limit) begin
                     res_status_in = bpq_pkg::STATUS_OVERFLOW;
                     state_in      = bpq_pkg::S_RESP;
                  end else if (count_ff == '0) begin
                     idx_in   = '0;
                     state_in = bpq_pkg::S_INS_PLACE;
                  end else begin
                     idx_in   = count_ff[AW-1:0];
                     rd_en    = 1'b1;
                     rd_addr  = cnt_m1[AW-1:0];
                     state_in = bpq_pkg::S_INS_CMP;
                  end
               end else begin
                  if (count_ff == '0) begin
                     res_status_in = bpq_pkg::STATUS_UNDERFLOW;
                     state_in      = bpq_pkg::S_RESP;
                  end else begin
                     rd_en    = 1'b1;
                     rd_addr  = '0;
                     idx_in   = AW'(1);
                     state_in = bpq_pkg::S_DEL_HEAD;
                  end
               end
            end
         end

         bpq_pkg::S_INS_CMP: begin
            // rd_data holds the entry just above slot idx
            if (rd_data.prio >= new_ff.prio) begin
               state_in = bpq_pkg::S_INS_PLACE;
            end else begin
               wr_en   = 1'b1;
               wr_addr = idx_ff;
               wr_data = rd_data;
               idx_in  = idx_ff - AW'(1);
               if (idx_ff == AW'(1)) begin
                  state_in = bpq_pkg::S_INS_PLACE;
               end else begin
                  rd_en   = 1'b1;
                  rd_addr = idx_ff - AW'(2);
               end
            end
         end

         bpq_pkg::S_INS_PLACE: begin
            wr_en    = 1'b1;
            wr_addr  = idx_ff;
            wr_data  = new_ff;
            count_in = count_ff + CW'(1);
            state_in = bpq_pkg::S_RESP;
         end

         bpq_pkg::S_DEL_HEAD: begin
            res_entry_in = rd_data;
            if (count_ff == CW'(1)) begin
               count_in = cnt_m1;
               state_in = bpq_pkg::S_RESP;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = idx_ff;
               state_in = bpq_pkg::S_DEL_SHIFT;
            end
         end

         bpq_pkg::S_DEL_SHIFT: begin
            wr_en   = 1'b1;
            wr_addr = idx_ff - AW'(1);
            wr_data = rd_data;
            if (idx_p1 < count_ff) begin
               rd_en   = 1'b1;
               rd_addr = idx_p1[AW-1:0];
               idx_in  = idx_p1[AW-1:0];
            end else begin
               count_in = cnt_m1;
               state_in = bpq_pkg::S_RESP;
            end
         end

         bpq_pkg::S_RESP: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_entry_in  = res_entry_ff;
               rsp_occ_in    = count_ff;
               state_in      = bpq_pkg::S_IDLE;
            end
         end

         default: begin
            state_in = bpq_pkg::S_IDLE;
         end
      endcase
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_status           = rsp_status_ff;
   assign rsp_removed_priority = rsp_entry_ff.prio;
   assign rsp_removed_payload  = rsp_entry_ff.payload;
   assign rsp_occupancy        = rsp_occ_ff;

   // count stays within the storage
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= bpq_pkg::DEPTH_CNT)
      else $error("entry count above depth");

   // the insert scan never runs below the head slot
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == bpq_pkg::S_INS_CMP) |-> (idx_ff != '0))
      else $error("insert scan index at zero");

   // ram writes only while moving or placing entries
   assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == bpq_pkg::S_INS_CMP || state_ff == bpq_pkg::S_INS_PLACE ||
                 state_ff == bpq_pkg::S_DEL_SHIFT))
      else $error("ram write outside of a shift");

   // an underflow reports an empty queue and no entry
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == bpq_pkg::STATUS_UNDERFLOW) |->
         (rsp_occ_ff == '0 && rsp_entry_ff == '0))
      else $error("underflow with entries held");

   // a dropped insert leaves the count alone
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == bpq_pkg::S_RESP && res_status_ff == bpq_pkg::STATUS_OVERFLOW)
         |-> $stable(count_ff))
      else $error("overflow changed the count");

endmodule

@@ tb/bounded_priority_queue_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_priority_queue_top_tb
// Self-checking bench for the bounded priority queue. A short directed table
// covers the empty, full-range, equal-priority and capacity-limit cases, then
// random insert/delete traffic runs under several capacity limits and idle
// patterns on both channels. Every result is compared against a queue model
// kept in the bench, stepped at each accepted item, or a typed row's values.
// ----------------------------------------------------------------------------
module bounded_priority_queue_top_tb;

   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int N_DIRECTED   = 27;
   localparam int PHASE_ITEMS  = 115;
   localparam int N_PHASES     = 12;
   localparam int BURST_ITEMS  = 24;
   localparam int DRAIN_CYCLES = 40;

   typedef struct packed {
      bpq_pkg::status_type         status;
      bpq_pkg::entry_type          removed;
      logic [bpq_pkg::CNT_W-1:0]   occupancy;
   } queue_result_type;

   typedef enum logic {ROW_ITEM, ROW_LIMIT} row_kind_type;

   typedef struct packed {
      row_kind_type                kind;
      logic                        op;
      bpq_pkg::entry_type          item;
      logic [bpq_pkg::CNT_W-1:0]   limit;
      logic                        typed;
      queue_result_type            exp;
   } stim_row_type;

   localparam bpq_pkg::entry_type NO_ENTRY = '0;
   localparam queue_result_type   NO_EXP   = '0;

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              req_valid = 1'b0;
   logic                              req_stall;
   logic                              req_opcode = bpq_pkg::OP_INSERT;
   logic [bpq_pkg::PRIO_W-1:0]        req_priority_req = '0;
   logic [bpq_pkg::PAYLOAD_W-1:0]     req_payload = '0;
   logic                              rsp_valid;
   logic                              rsp_stall = 1'b0;
   logic [1:0]                        rsp_status;
   logic [bpq_pkg::PRIO_W-1:0]        rsp_removed_priority;
   logic [bpq_pkg::PAYLOAD_W-1:0]     rsp_removed_payload;
   logic [bpq_pkg::CNT_W-1:0]         rsp_occupancy;
   logic                              csr_wr_en = 1'b0;
   logic [bpq_pkg::CNT_W-1:0]         csr_wr_data = '0;

   int                                cycle_count = 0;
   int                                fail_count = 0;
   int                                send_idle_pct = 0;
   int                                recv_stall_pct = 0;

   // queue model state
   logic [bpq_pkg::PRIO_W-1:0]        held_prio [bpq_pkg::DEPTH];
   logic [bpq_pkg::PAYLOAD_W-1:0]     held_payload [bpq_pkg::DEPTH];
   int                                held_count = 0;
   logic [bpq_pkg::CNT_W-1:0]         cap_limit = bpq_pkg::LIMIT_RESET;

   queue_result_type                  pending_results [$];
   stim_row_type                      directed_checks [$];

   stim_row_type directed_rows [N_DIRECTED] = '{
      '{ROW_ITEM, bpq_pkg::OP_DELETE, NO_ENTRY, 5'd0, 1'b1,
        '{bpq_pkg::STATUS_UNDERFLOW, NO_ENTRY, 5'd0}},
      '{ROW_ITEM, bpq_pkg::OP_INSERT, '{8'h00, 32'h0000_0000}, 5'd0, 1'b1,
        '{bpq_pkg::STATUS_OK, NO_ENTRY, 5'd1}},
      '{ROW_ITEM, bpq_pkg::OP_INSERT, '{8'hff, 32'hffff_ffff}, 5'd0, 1'b1,
        '{bpq_pkg::STATUS_OK, NO_ENTRY, 5'd2}},
      '{ROW_ITEM, bpq_pkg::OP_INSERT, '{8'h80, 32'ha5a5_a5a5}, 5'd0, 1'b0, NO_EXP},
      '{ROW_ITEM, bpq_pkg::OP_INSERT, '{8'h80, 32'h5a5a_5a5a}, 5'd0, 1'b0, NO_EXP},
      '{ROW_ITEM, bpq_pkg::OP_INSERT, '{8'hff, 32'h0000_0001}, 5'd0, 1'b0, NO_EXP},
      '{ROW_ITEM, bpq_pkg::OP_DELETE, NO_ENTRY, 5'd0, 1'b1,
        '{bpq_pkg::STATUS_OK, '{8'hff, 32'hffff_ffff}, 5'd4}},
      '{ROW_ITEM, bpq_pkg::OP_DELETE, NO_ENTRY, 5'd0, 1'b1,
        '{bpq_pkg::STATUS_OK, '{8'hff, 32'h0000_0001}, 5'd3}},
      '{ROW_ITEM, bpq_pkg::OP_DELETE, NO_ENTRY, 5'd0, 1'b0, NO_EXP},
      '{ROW_ITEM, bpq_pkg::OP_DELETE, NO_ENTRY, 5'd0, 1'b0, NO_EXP},
      '{ROW_ITEM, bpq_pkg::OP_DELETE, NO_ENTRY, 5'd0, 1'b1,
        '{bpq_pkg::STATUS_OK, '{8'h00, 32'h0000_0000}, 5'd0}},
      '{ROW_ITEM, bpq_pkg::OP_DELETE, NO_ENTRY, 5'd0, 1'b1,
        '{bpq_pkg::STATUS_UNDERFLOW, NO_ENTRY, 5'd0}},
      '{ROW_LIMIT, bpq_pkg::OP_INSERT, NO_ENTRY, 5'd0, 1'b0, NO_EXP},
      '{ROW_ITEM, bpq_pkg::OP_INSERT, '{8'hc8, 32'hdead_beef}, 5'd0, 1'b1,
        '{bpq_pkg::STATUS_OVERFLOW, NO_ENTRY, 5'd0}},
      '{ROW_ITEM, bpq_pkg::OP_DELETE, NO_ENTRY, 5'd0, 1'b1,
        '{bpq_pkg::STATUS_UNDERFLOW, NO_ENTRY, 5'd0}},
      '{ROW_LIMIT, bpq_pkg::OP_INSERT, NO_ENTRY, 5'd2, 1'b0, NO_EXP},
      '{ROW_ITEM, bpq_pkg::OP_INSERT, '{8'h07, 32'h1111_1111}, 5'd0, 1'b0, NO_EXP},
      '{ROW_ITEM, bpq_pkg::OP_INSERT, '{8'h09, 32'h2222_2222}, 5'd0, 1'b0, NO_EXP},
      '{ROW_ITEM, bpq_pkg::OP_INSERT, '{8'h03, 32'h3333_3333}, 5'd0, 1'b1,
        '{bpq_pkg::STATUS_OVERFLOW, NO_ENTRY, 5'd2}},
      '{ROW_LIMIT, bpq_pkg::OP_INSERT, NO_ENTRY, 5'd1, 1'b0, NO_EXP},
      '{ROW_ITEM, bpq_pkg::OP_INSERT, '{8'h09, 32'h4444_4444}, 5'd0, 1'b1,
        '{bpq_pkg::STATUS_OVERFLOW, NO_ENTRY, 5'd2}},
      '{ROW_ITEM, bpq_pkg::OP_DELETE, NO_ENTRY, 5'd0, 1'b0, NO_EXP},
      '{ROW_ITEM, bpq_pkg::OP_INSERT, '{8'h05, 32'h5555_5555}, 5'd0, 1'b1,
        '{bpq_pkg::STATUS_OVERFLOW, NO_ENTRY, 5'd1}},
      '{ROW_ITEM, bpq_pkg::OP_DELETE, NO_ENTRY, 5'd0, 1'b0, NO_EXP},
      '{ROW_LIMIT, bpq_pkg::OP_INSERT, NO_ENTRY, 5'd31, 1'b0, NO_EXP},
      '{ROW_ITEM, bpq_pkg::OP_INSERT, '{8'h01, 32'h0000_0000}, 5'd0, 1'b0, NO_EXP},
      '{ROW_ITEM, bpq_pkg::OP_DELETE, NO_ENTRY, 5'd0, 1'b0, NO_EXP}
   };

   logic [bpq_pkg::CNT_W-1:0] phase_limits [N_PHASES] = '{
      5'd16, 5'd31, 5'd4, 5'd0, 5'd17, 5'd1, 5'd10, 5'd16, 5'd2, 5'd31, 5'd15, 5'd16
   };

   bounded_priority_queue_top u_top (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_opcode           (req_opcode),
      .req_priority_req     (req_priority_req),
      .req_payload          (req_payload),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_status           (rsp_status),
      .rsp_removed_priority (rsp_removed_priority),
      .rsp_removed_payload  (rsp_removed_payload),
      .rsp_occupancy        (rsp_occupancy),
      .csr_wr_en            (csr_wr_en),
      .csr_wr_data          (csr_wr_data)
   );

   always #2 clock = ~clock;

   function automatic queue_result_type queue_apply(
         input logic op,
         input logic [bpq_pkg::PRIO_W-1:0] prio,
         input logic [bpq_pkg::PAYLOAD_W-1:0] data);
      queue_result_type res;
      int               lim;
      int               pos;
      int               i;
      res = '{bpq_pkg::STATUS_OK, NO_ENTRY, '0};
      lim = (cap_limit > bpq_pkg::DEPTH_CNT) ? bpq_pkg::DEPTH : int'(cap_limit);
      if (op == bpq_pkg::OP_INSERT) begin
         if (held_count >= lim || held_count >= bpq_pkg::DEPTH) begin
            res.status = bpq_pkg::STATUS_OVERFLOW;
         end else begin
            pos = 0;
            while (pos < held_count && held_prio[pos] >= prio) pos++;
            for (i = held_count; i > pos; i--) begin
               held_prio[i]    = held_prio[i-1];
               held_payload[i] = held_payload[i-1];
            end
            held_prio[pos]    = prio;
            held_payload[pos] = data;
            held_count++;
         end
      end else begin
         if (held_count == 0) begin
            res.status = bpq_pkg::STATUS_UNDERFLOW;
         end else begin
            res.removed = '{held_prio[0], held_payload[0]};
            for (i = 1; i < held_count; i++) begin
               held_prio[i-1]    = held_prio[i];
               held_payload[i-1] = held_payload[i];
            end
            held_count--;
         end
      end
      res.occupancy = bpq_pkg::CNT_W'(held_count);
      return res;
   endfunction

   task automatic report_mismatch(input string what);
      $display("mismatch at cycle %0d: %s", cycle_count, what);
      fail_count++;
   endtask

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // receiver backpressure
   always @(negedge clock) begin
      rsp_stall <= (recv_stall_pct > 0) && ($urandom_range(99) < recv_stall_pct);
   end

   // model update and result check
   always @(posedge clock) begin
      queue_result_type exp;
      stim_row_type     row;
      if (reset) begin
         held_count = 0;
         cap_limit  = bpq_pkg::LIMIT_RESET;
         pending_results.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_results.size() == 0) begin
               report_mismatch("result with nothing pending");
            end else begin
               exp = pending_results.pop_front();
               if (rsp_status !== exp.status)
                  report_mismatch($sformatf("status %0d, expected %0d",
                                            rsp_status, exp.status));
               if (rsp_removed_priority !== exp.removed.prio)
                  report_mismatch($sformatf("removed_priority %h, expected %h",
                                            rsp_removed_priority, exp.removed.prio));
               if (rsp_removed_payload !== exp.removed.payload)
                  report_mismatch($sformatf("removed_payload %h, expected %h",
                                            rsp_removed_payload, exp.removed.payload));
               if (rsp_occupancy !== exp.occupancy)
                  report_mismatch($sformatf("occupancy %0d, expected %0d",
                                            rsp_occupancy, exp.occupancy));
            end
         end
         if (csr_wr_en) cap_limit = csr_wr_data;
         if (req_valid && !req_stall) begin
            exp = queue_apply(req_opcode, req_priority_req, req_payload);
            if (directed_checks.size() > 0) begin
               row = directed_checks.pop_front();
               if (row.typed) exp = row.exp;
            end
            pending_results.push_back(exp);
         end
      end
   end

   task automatic send_item(input logic op, input logic [bpq_pkg::PRIO_W-1:0] prio,
                            input logic [bpq_pkg::PAYLOAD_W-1:0] data);
      @(negedge clock);
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_opcode       <= op;
      req_priority_req <= prio;
      req_payload      <= data;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic wait_results_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
   endtask

   task automatic write_limit(input logic [bpq_pkg::CNT_W-1:0] value);
      wait_results_drained();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   initial begin
      int                          ins_pct;
      logic                        op;
      logic [bpq_pkg::PRIO_W-1:0]  prio;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r]) begin
         if (directed_rows[r].kind == ROW_LIMIT) begin
            write_limit(directed_rows[r].limit);
         end else begin
            directed_checks.push_back(directed_rows[r]);
            send_item(directed_rows[r].op, directed_rows[r].item.prio,
                      directed_rows[r].item.payload);
         end
      end

      for (int ph = 0; ph < N_PHASES; ph++) begin
         write_limit(phase_limits[ph]);
         case (ph % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 47; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 47; end
            default: begin send_idle_pct = 21; recv_stall_pct = 21; end
         endcase
         ins_pct = 50;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (n % BURST_ITEMS == 0) begin
               case ($urandom_range(2))
                  0: ins_pct = 85;
                  1: ins_pct = 50;
                  default: ins_pct = 15;
               endcase
            end
            op = ($urandom_range(99) < ins_pct) ? bpq_pkg::OP_INSERT : bpq_pkg::OP_DELETE;
            case ($urandom_range(9))
               0, 1, 2, 3, 4: prio = bpq_pkg::PRIO_W'($urandom_range(3));
               5, 6, 7: prio = bpq_pkg::PRIO_W'($urandom_range(255));
               8: prio = '0;
               default: prio = '1;
            endcase
            send_item(op, prio, $urandom);
         end
      end

      wait_results_drained();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fail_count == 0 && pending_results.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

@@ files.f @@
rtl/bpq_pkg.sv
rtl/bpq_ram.sv
rtl/bounded_priority_queue_top.sv
tb/bounded_priority_queue_top_tb.sv
